FILE: hdl/cfd_pkg.sv
// ============================================================================
// cfd_pkg
// Shared types, constants and the crc16 byte update for the control-frame
// deframer.
// ============================================================================
package cfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int VALUE_W     = 16;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 8;
    localparam int COUNT_W     = 4;

    // frame layout
    localparam logic [BYTE_W-1:0]  HDR0_BYTE   = 8'h5A;
    localparam logic [BYTE_W-1:0]  HDR1_BYTE   = 8'hA5;
    localparam logic [BYTE_W-1:0]  TYPE_CTRL   = 8'h01;
    localparam logic [BYTE_W-1:0]  LEN_CTRL    = 8'h04;
    localparam logic [COUNT_W-1:0] FRAME_BYTES = 4'd10;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = 4'd15;

    // modbus crc16
    localparam logic [VALUE_W-1:0] CRC_POLY = 16'hA001;
    localparam logic [VALUE_W-1:0] CRC_INIT = 16'hFFFF;

    // limit register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PWM_LOW  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PWM_HIGH = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CUR_LOW  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_CUR_HIGH = 8'd3;

    // limit reset values
    localparam logic signed [VALUE_W-1:0] PWM_LOW_RESET  = -16'sd10000;
    localparam logic signed [VALUE_W-1:0] PWM_HIGH_RESET = 16'sd10000;
    localparam logic signed [VALUE_W-1:0] CUR_LOW_RESET  = -16'sd2000;
    localparam logic signed [VALUE_W-1:0] CUR_HIGH_RESET = 16'sd2000;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK     = 2'd0,
        STATUS_FORMAT = 2'd1,
        STATUS_CRC    = 2'd2,
        STATUS_RANGE  = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] pwm_low;
        logic signed [VALUE_W-1:0] pwm_high;
        logic signed [VALUE_W-1:0] cur_low;
        logic signed [VALUE_W-1:0] cur_high;
    } limits_t;

    typedef struct packed {
        status_t                   status;
        logic signed [VALUE_W-1:0] pwm_value;
        logic signed [VALUE_W-1:0] current_value;
    } result_t;

    // one byte of the reflected crc, bit by bit
    function automatic logic [VALUE_W-1:0] crc16_byte(input logic [VALUE_W-1:0] crc,
                                                      input logic [BYTE_W-1:0]  b);
        logic [VALUE_W-1:0] c;
        c = crc ^ {{(VALUE_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: hdl/cfd_byte_if.sv
// ============================================================================
// cfd_byte_if
// Received byte channel: one frame byte and its end-of-frame flag.
// ============================================================================
interface cfd_byte_if import cfd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_end;

    modport source (output valid, rx_byte, frame_end, input ready);
    modport sink (input valid, rx_byte, frame_end, output ready);
endinterface

FILE: hdl/cfd_result_if.sv
// ============================================================================
// cfd_result_if
// Result channel: frame status and the parsed command values.
// ============================================================================
interface cfd_result_if import cfd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] pwm_value;
    logic signed [VALUE_W-1:0] current_value;

    modport source (output valid, status, pwm_value, current_value, input ready);
    modport sink (input valid, status, pwm_value, current_value, output ready);
endinterface

FILE: hdl/cfd_cfg_if.sv
// ============================================================================
// cfd_cfg_if
// Configuration write channel: register index and write data.
// ============================================================================
interface cfd_cfg_if import cfd_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] reg_index;
    logic [VALUE_W-1:0]     wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink (input valid, reg_index, wdata, output ready);
endinterface

FILE: hdl/cfd_cfg_regs.sv
// ============================================================================
// cfd_cfg_regs
// Limit registers for the pwm and current range check.
// ============================================================================
module cfd_cfg_regs import cfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cfd_cfg_if.sink     cfg,
    output limits_t     limits
);

    limits_t limits_reg;
    logic    wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;
    assign limits    = limits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.pwm_low  <= PWM_LOW_RESET;
            limits_reg.pwm_high <= PWM_HIGH_RESET;
            limits_reg.cur_low  <= CUR_LOW_RESET;
            limits_reg.cur_high <= CUR_HIGH_RESET;
        end
        else if (wr_en)
        begin
            // unknown indexes are dropped
            unique case (cfg.reg_index)
                CFG_PWM_LOW:  limits_reg.pwm_low  <= cfg.wdata;
                CFG_PWM_HIGH: limits_reg.pwm_high <= cfg.wdata;
                CFG_CUR_LOW:  limits_reg.cur_low  <= cfg.wdata;
                CFG_CUR_HIGH: limits_reg.cur_high <= cfg.wdata;
                default:      limits_reg <= limits_reg;
            endcase
        end
    end

    a_pwm_low_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.valid && cfg.ready && cfg.reg_index == CFG_PWM_LOW
        |=> limits_reg.pwm_low == $past(cfg.wdata))
        else $error("pwm low limit not written");

endmodule

FILE: hdl/cfd_frame_parser.sv
// ============================================================================
// cfd_frame_parser
// Per-frame state (byte count, crc, format flag, value shifters) and the
// status check made on the final byte.
// ============================================================================
module cfd_frame_parser import cfd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              frame_end,
    input  limits_t           limits,
    output result_t           result
);

    localparam logic [COUNT_W-1:0] POS_HDR0   = 4'd0;
    localparam logic [COUNT_W-1:0] POS_HDR1   = 4'd1;
    localparam logic [COUNT_W-1:0] POS_TYPE   = 4'd2;
    localparam logic [COUNT_W-1:0] POS_LEN    = 4'd3;
    localparam logic [COUNT_W-1:0] POS_PWM_L  = 4'd4;
    localparam logic [COUNT_W-1:0] POS_PWM_H  = 4'd5;
    localparam logic [COUNT_W-1:0] POS_CUR_L  = 4'd6;
    localparam logic [COUNT_W-1:0] POS_CUR_H  = 4'd7;
    localparam logic [COUNT_W-1:0] POS_CRC_L  = 4'd8;
    localparam logic [COUNT_W-1:0] CRC_BYTES  = 4'd8;

    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [VALUE_W-1:0] crc_accum_reg, crc_accum_next;
    logic               format_bad_reg, format_bad_next;
    logic [VALUE_W-1:0] pwm_shift_reg, pwm_shift_next;
    logic [VALUE_W-1:0] current_shift_reg, current_shift_next;
    logic [BYTE_W-1:0]  crc_low_byte_reg, crc_low_byte_next;

    logic               length_ok;
    logic               crc_ok;
    logic               pwm_ok;
    logic               cur_ok;
    status_t            status;

    // byte position decode
    always_comb
    begin
        crc_accum_next     = crc_accum_reg;
        format_bad_next    = format_bad_reg;
        pwm_shift_next     = pwm_shift_reg;
        current_shift_next = current_shift_reg;
        crc_low_byte_next  = crc_low_byte_reg;
        if (byte_count_reg < CRC_BYTES)
        begin
            crc_accum_next = crc16_byte(crc_accum_reg, rx_byte);
        end
        unique case (byte_count_reg)
            POS_HDR0:  format_bad_next = format_bad_reg || (rx_byte != HDR0_BYTE);
            POS_HDR1:  format_bad_next = format_bad_reg || (rx_byte != HDR1_BYTE);
            POS_TYPE:  format_bad_next = format_bad_reg || (rx_byte != TYPE_CTRL);
            POS_LEN:   format_bad_next = format_bad_reg || (rx_byte != LEN_CTRL);
            POS_PWM_L,
            POS_PWM_H: pwm_shift_next = {rx_byte, pwm_shift_reg[VALUE_W-1:BYTE_W]};
            POS_CUR_L,
            POS_CUR_H: current_shift_next = {rx_byte, current_shift_reg[VALUE_W-1:BYTE_W]};
            POS_CRC_L: crc_low_byte_next = rx_byte;
            default:   crc_low_byte_next = crc_low_byte_reg;
        endcase
        byte_count_next = (byte_count_reg == COUNT_MAX) ? COUNT_MAX
                                                        : byte_count_reg + 4'd1;
    end

    // checks on the final byte
    assign length_ok = (byte_count_next == FRAME_BYTES) && !format_bad_next;
    assign crc_ok    = ({rx_byte, crc_low_byte_next} == crc_accum_next);
    assign pwm_ok    = ($signed(pwm_shift_next) >= limits.pwm_low)
                    && ($signed(pwm_shift_next) <= limits.pwm_high);
    assign cur_ok    = ($signed(current_shift_next) >= limits.cur_low)
                    && ($signed(current_shift_next) <= limits.cur_high);

    always_comb
    begin
        priority if (!length_ok)
            status = STATUS_FORMAT;
        else if (!crc_ok)
            status = STATUS_CRC;
        else if (!pwm_ok || !cur_ok)
            status = STATUS_RANGE;
        else
            status = STATUS_OK;
    end

    assign result.status        = status;
    assign result.pwm_value     = (status == STATUS_OK) ? pwm_shift_next : '0;
    assign result.current_value = (status == STATUS_OK) ? current_shift_next : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            crc_accum_reg     <= CRC_INIT;
            format_bad_reg    <= 1'b0;
            pwm_shift_reg     <= '0;
            current_shift_reg <= '0;
            crc_low_byte_reg  <= '0;
        end
        else if (step)
        begin
            if (frame_end)
            begin
                byte_count_reg    <= '0;
                crc_accum_reg     <= CRC_INIT;
                format_bad_reg    <= 1'b0;
                pwm_shift_reg     <= '0;
                current_shift_reg <= '0;
                crc_low_byte_reg  <= '0;
            end
            else
            begin
                byte_count_reg    <= byte_count_next;
                crc_accum_reg     <= crc_accum_next;
                format_bad_reg    <= format_bad_next;
                pwm_shift_reg     <= pwm_shift_next;
                current_shift_reg <= current_shift_next;
                crc_low_byte_reg  <= crc_low_byte_next;
            end
        end
    end

    a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && frame_end |=> byte_count_reg == '0 && crc_accum_reg == CRC_INIT)
        else $error("frame state not cleared after final byte");

    a_ok_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.status == STATUS_OK
        |-> result.pwm_value >= limits.pwm_low && result.pwm_value <= limits.pwm_high
            && result.current_value >= limits.cur_low
            && result.current_value <= limits.cur_high)
        else $error("ok status with value outside limits");

    a_fail_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        result.status != STATUS_OK |-> result.pwm_value == '0 && result.current_value == '0)
        else $error("failed frame carries nonzero values");

endmodule

FILE: hdl/control_frame_deframer_core.sv
// ============================================================================
// control_frame_deframer_core
// Control-frame deframer: checks header, length, modbus crc16 and command
// limits of 10-byte frames and reports one result per frame.
// ============================================================================
//
//  channel     dir  handshake      payload
//  ----------  ---  -------------  ---------------------------------------
//  byte_in     in   valid / ready  rx_byte[7:0], frame_end
//  result_out  out  valid / ready  status[1:0], pwm_value, current_value
//  cfg         in   valid / ready  reg_index[7:0], wdata[15:0]
//
//  one byte per cycle while byte_in is not stalled; each byte is held in the input
//  register and is folded into the frame state when it steps
//  a final byte that steps loads its result into the output register
//  byte_in stalls only when a final byte waits on a result not yet taken
//  cfg is always ready; limits apply to the next final byte checked
//  reset (rst_n low, asynchronous) empties both registers and clears frame state
//
module control_frame_deframer_core import cfd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    cfd_byte_if.sink     byte_in,
    cfd_result_if.source result_out,
    cfd_cfg_if.sink      cfg
);

    // input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_end_reg;

    // output register
    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg;

    limits_t           limits;
    result_t           result;

    logic              out_stall;
    logic              step;
    logic              in_xfer;

    // an output register that holds an untaken result blocks only a final byte
    assign out_stall     = out_valid_reg && !result_out.ready;
    assign step          = in_valid_reg && !(in_end_reg && out_stall);
    assign byte_in.ready = !in_valid_reg || step;
    assign in_xfer       = byte_in.valid && byte_in.ready;

    cfd_cfg_regs u_cfg_regs
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .limits (limits)
    );

    cfd_frame_parser u_frame_parser
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rx_byte   (in_byte_reg),
        .frame_end (in_end_reg),
        .limits    (limits),
        .result    (result)
    );

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_in.ready)
        begin
            in_valid_reg <= byte_in.valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            in_byte_reg <= byte_in.rx_byte;
            in_end_reg  <= byte_in.frame_end;
        end
    end

    // a result is loaded when the final byte steps, and held until transfer
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (step && in_end_reg)
            out_valid_next = 1'b1;
        else if (result_out.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && in_end_reg)
        begin
            out_data_reg <= result;
        end
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.status        = out_data_reg.status;
    assign result_out.pwm_value     = out_data_reg.pwm_value;
    assign result_out.current_value = out_data_reg.current_value;

    a_final_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        step && in_end_reg |=> out_valid_reg)
        else $error("final byte stepped without a result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_stall |=> out_valid_reg && $stable(out_data_reg))
        else $error("pending result overwritten or dropped");

endmodule
